### rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, constants, register set and datapath operations of the
// line follower PID drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   localparam int MAX_SENSORS = 8;
   localparam int FRAC_BITS   = 12;
   localparam int ONE         = 1 << FRAC_BITS;
   localparam int LINE_THRESH = ONE / 100;
   localparam int TURN        = (ONE * 35 + 50) / 100;

   // field widths
   localparam int SENSOR_W = 13;
   localparam int SPD_W    = 14;
   localparam int POS_W    = 16;
   localparam int CFG_W    = 15;
   localparam int IDX_W    = 3;

   // internal widths
   localparam int SEEN_W  = 4;
   localparam int CTR_W   = 3;
   localparam int VAL_W   = 14;
   localparam int VSUM_W  = 17;
   localparam int IWS_W   = 19;
   localparam int W_W     = 22;
   localparam int DVD_W   = 32;
   localparam int REM_W   = 18;
   localparam int CNT_W   = $clog2(DVD_W);
   localparam int INTEG_W = 17;
   localparam int DER_W   = 24;
   localparam int MA_W    = 16;
   localparam int MB_W    = 25;
   localparam int PROD_W  = 42;
   localparam int ACC_W   = 44;
   localparam int CORR_W  = 15;
   localparam int FWD_W   = 17;

   // reciprocal of 20: x / 20 == (x * RECIP_20) >> RECIP_SHIFT for x < 2^16
   localparam int RECIP_20    = 52429;
   localparam int RECIP_SHIFT = 20;

   // register indexes
   localparam logic [IDX_W-1:0] REG_GAIN_P         = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_I         = 3'd1;
   localparam logic [IDX_W-1:0] REG_GAIN_D         = 3'd2;
   localparam logic [IDX_W-1:0] REG_BASE_SPEED     = 3'd3;
   localparam logic [IDX_W-1:0] REG_MAX_SPEED      = 3'd4;
   localparam logic [IDX_W-1:0] REG_MAX_CORRECTION = 3'd5;
   localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd6;
   localparam logic [IDX_W-1:0] REG_SEARCH_SPEED   = 3'd7;

   typedef struct packed {
      logic [14:0] gain_p;
      logic [14:0] gain_i;
      logic [14:0] gain_d;
      logic [12:0] base_speed;
      logic [12:0] max_speed;
      logic [13:0] max_correction;
      logic [14:0] integral_limit;
      logic [12:0] search_speed;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCUM,
      OP_CENTRE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_POSITION,
      OP_INT_MUL,
      OP_INTEG,
      OP_DERIV,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_SUM,
      OP_CORR,
      OP_RESULT,
      OP_EMPTY
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

endpackage

### rtl/lfpd_req_if.sv
// ----------------------------------------------------------------------------
// lfpd_req_if
// Sensor reading channel: valid/ready with one reading per word.
// ----------------------------------------------------------------------------
interface lfpd_req_if
   import lfpd_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SENSOR_W-1:0] sensor_value;
   logic                last_in_frame;
   logic                empty_frame;

   modport source (output valid, sensor_value, last_in_frame, empty_frame, input ready);
   modport sink   (input valid, sensor_value, last_in_frame, empty_frame, output ready);
endinterface

### rtl/lfpd_rsp_if.sv
// ----------------------------------------------------------------------------
// lfpd_rsp_if
// Drive command channel: valid/ready with one command per word.
// ----------------------------------------------------------------------------
interface lfpd_rsp_if
   import lfpd_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [SPD_W-1:0] left_speed;
   logic signed [SPD_W-1:0] right_speed;
   logic                    line_found;
   logic signed [POS_W-1:0] line_position;

   modport source (output valid, left_speed, right_speed, line_found, line_position,
                   input ready);
   modport sink   (input valid, left_speed, right_speed, line_found, line_position,
                   output ready);
endinterface

### rtl/lfpd_csr.sv
// ----------------------------------------------------------------------------
// lfpd_csr
// Configuration register file: gains, speeds and limits.
// ----------------------------------------------------------------------------
module lfpd_csr
   import lfpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_write_data,
   output cfg_type          cfg
);

   cfg_type regs_ff;
   cfg_type regs_in;

   // register write decode, truncated to each register's width
   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_GAIN_P:         regs_in.gain_p         = csr_write_data;
            REG_GAIN_I:         regs_in.gain_i         = csr_write_data;
            REG_GAIN_D:         regs_in.gain_d         = csr_write_data;
            REG_BASE_SPEED:     regs_in.base_speed     = csr_write_data[12:0];
            REG_MAX_SPEED:      regs_in.max_speed      = csr_write_data[12:0];
            REG_MAX_CORRECTION: regs_in.max_correction = csr_write_data[13:0];
            REG_INTEGRAL_LIMIT: regs_in.integral_limit = csr_write_data;
            REG_SEARCH_SPEED:   regs_in.search_speed   = csr_write_data[12:0];
            default:            regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.gain_p         <= 15'd3686;
         regs_ff.gain_i         <= 15'd205;
         regs_ff.gain_d         <= 15'd737;
         regs_ff.base_speed     <= 13'd3277;
         regs_ff.max_speed      <= 13'd4096;
         regs_ff.max_correction <= 14'd3482;
         regs_ff.integral_limit <= 15'd8192;
         regs_ff.search_speed   <= 13'd2253;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign cfg = regs_ff;

endmodule

### rtl/lfpd_ctrl.sv
// ----------------------------------------------------------------------------
// lfpd_ctrl
// Sequencer: accepts readings, steps the datapath through centroid division
// and PID, and owns the result word's valid flag.
// ----------------------------------------------------------------------------
module lfpd_ctrl
   import lfpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last_in_frame,
   input  logic    req_empty_frame,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CENTRE, S_DIV_INIT, S_DIV, S_POS, S_INT_MUL, S_INTEG, S_DERIV,
      S_MUL_P, S_MUL_I, S_MUL_D, S_SUM, S_CORR, S_RESULT, S_EMPTY
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             accept;
   logic             out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // command per state
   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE:     cmd.op = (accept && !req_empty_frame) ? OP_ACCUM : OP_NONE;
         S_CENTRE:   cmd.op = OP_CENTRE;
         S_DIV_INIT: cmd.op = OP_DIV_INIT;
         S_DIV:      cmd.op = OP_DIV_STEP;
         S_POS:      cmd.op = OP_POSITION;
         S_INT_MUL:  cmd.op = OP_INT_MUL;
         S_INTEG:    cmd.op = OP_INTEG;
         S_DERIV:    cmd.op = OP_DERIV;
         S_MUL_P:    cmd.op = OP_MUL_P;
         S_MUL_I:    cmd.op = OP_MUL_I;
         S_MUL_D:    cmd.op = OP_MUL_D;
         S_SUM:      cmd.op = OP_SUM;
         S_CORR:     cmd.op = OP_CORR;
         S_RESULT:   cmd.op = out_free ? OP_RESULT : OP_NONE;
         S_EMPTY:    cmd.op = out_free ? OP_EMPTY : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // state, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new word, or drop the one just taken
         if ((state_ff == S_RESULT || state_ff == S_EMPTY) && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_empty_frame)        state_ff <= S_EMPTY;
                  else if (req_last_in_frame) state_ff <= S_CENTRE;
               end
            end
            S_CENTRE:   state_ff <= S_DIV_INIT;
            S_DIV_INIT: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (cnt_ff == CNT_W'(DVD_W - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_POS;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_POS:     state_ff <= S_INT_MUL;
            S_INT_MUL: state_ff <= S_INTEG;
            S_INTEG:   state_ff <= S_DERIV;
            S_DERIV:   state_ff <= S_MUL_P;
            S_MUL_P:   state_ff <= S_MUL_I;
            S_MUL_I:   state_ff <= S_MUL_D;
            S_MUL_D:   state_ff <= S_SUM;
            S_SUM:     state_ff <= S_CORR;
            S_CORR:    state_ff <= S_RESULT;
            S_RESULT, S_EMPTY: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // an empty frame goes straight to its stop command
   a_empty_next: assert property (@(posedge clock) disable iff (reset)
      (accept && req_empty_frame) |=> (state_ff == S_EMPTY))
      else $error("empty frame did not lead to stop command");

   // divider step count only runs during division
   a_cnt_div: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (state_ff == S_DIV))
      else $error("step counter active outside division");

   // a new result word only comes from a result or stop state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESULT || $past(state_ff) == S_EMPTY))
      else $error("result word raised from wrong state");

   // a pending word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> (cmd.op != OP_RESULT && cmd.op != OP_EMPTY))
      else $error("result loaded over pending word");

endmodule

### rtl/lfpd_dp.sv
// ----------------------------------------------------------------------------
// lfpd_dp
// Datapath: frame sums, restoring divider, shared multiplier, PID state and
// the result word register.
// ----------------------------------------------------------------------------
module lfpd_dp
   import lfpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  cfg_type                 cfg,
   input  logic [SENSOR_W-1:0]     sensor_value,
   output logic signed [SPD_W-1:0] left_speed,
   output logic signed [SPD_W-1:0] right_speed,
   output logic                    line_found,
   output logic signed [POS_W-1:0] line_position
);

   // frame and PID state
   logic signed [VSUM_W-1:0]  vsum_ff, vsum_in;
   logic signed [IWS_W-1:0]   iws_ff, iws_in;
   logic [SEEN_W-1:0]         seen_ff, seen_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [POS_W-1:0]   perr_ff, perr_in;
   logic signed [DER_W-1:0]   pder_ff, pder_in;
   // working registers
   logic signed [W_W-1:0]     w_ff, w_in;
   logic                      det_ff, det_in;
   logic                      neg_ff, neg_in;
   logic [DVD_W-1:0]          dvd_ff, dvd_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic signed [DER_W-1:0]   der_ff, der_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [CORR_W-1:0]  corr_ff, corr_in;
   // result word
   logic signed [SPD_W-1:0]   left_ff, left_in;
   logic signed [SPD_W-1:0]   right_ff, right_in;
   logic                      odet_ff, odet_in;
   logic signed [POS_W-1:0]   opos_ff, opos_in;

   // scratch
   logic signed [VAL_W-1:0]   v;
   logic [CTR_W-1:0]          centre;
   logic [W_W-1:0]            wmag;
   logic [REM_W-1:0]          trial;
   logic [REM_W-1:0]          divisor;
   logic [MA_W-1:0]           mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic [POS_W:0]            pmag;
   logic signed [INTEG_W:0]   e20;
   logic signed [INTEG_W:0]   isum;
   logic signed [INTEG_W:0]   ilim;
   logic signed [POS_W:0]     ediff;
   logic signed [DER_W-2:0]   raw;
   logic signed [DER_W:0]     dsum;
   logic signed [ACC_W-1:0]   tacc;
   logic signed [ACC_W-FRAC_BITS-1:0] cq;
   logic signed [ACC_W-FRAC_BITS-1:0] cmax;
   logic signed [FWD_W-1:0]   fwd;
   logic signed [FWD_W-1:0]   lsum;
   logic signed [FWD_W-1:0]   rsum;
   logic signed [FWD_W-1:0]   vmax;

   // shared multiplier, one product per cycle, registered in prod_ff
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      pmag  = pos_ff[POS_W-1] ? (POS_W+1)'(-$signed({pos_ff[POS_W-1], pos_ff}))
                              : (POS_W+1)'(pos_ff);
      case (cmd.op)
         OP_INT_MUL: begin
            mul_a = MA_W'(RECIP_20);
            mul_b = MB_W'({1'b0, pmag});
         end
         OP_MUL_P: begin
            mul_a = MA_W'(cfg.gain_p);
            mul_b = MB_W'(pos_ff);
         end
         OP_MUL_I: begin
            mul_a = MA_W'(cfg.gain_i);
            mul_b = MB_W'(integ_ff);
         end
         OP_MUL_D: begin
            mul_a = MA_W'(cfg.gain_d);
            mul_b = MB_W'(der_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // next-state logic per operation
   always_comb begin
      vsum_in  = vsum_ff;  iws_in   = iws_ff;  seen_in = seen_ff;
      integ_in = integ_ff; perr_in  = perr_ff; pder_in = pder_ff;
      w_in     = w_ff;     det_in   = det_ff;  neg_in  = neg_ff;
      dvd_in   = dvd_ff;   rem_in   = rem_ff;  pos_in  = pos_ff;
      der_in   = der_ff;   acc_in   = acc_ff;  corr_in = corr_ff;
      left_in  = left_ff;  right_in = right_ff;
      odet_in  = odet_ff;  opos_in  = opos_ff;
      prod_in  = PROD_W'($signed({1'b0, mul_a}) * mul_b);

      v       = $signed(VAL_W'(ONE) - {1'b0, sensor_value});
      centre  = CTR_W'((seen_ff - 1'b1) >> 1);
      wmag    = w_ff[W_W-1] ? W_W'(-w_ff) : W_W'(w_ff);
      divisor = REM_W'(vsum_ff[VSUM_W-1:0]);
      trial   = {rem_ff[REM_W-2:0], dvd_ff[DVD_W-1]};
      e20     = pos_ff[POS_W-1] ? -$signed((INTEG_W+1)'(prod_ff >>> RECIP_SHIFT))
                                :  $signed((INTEG_W+1)'(prod_ff >>> RECIP_SHIFT));
      isum    = (INTEG_W+1)'(integ_ff) + e20;
      ilim    = $signed((INTEG_W+1)'(cfg.integral_limit));
      ediff   = (POS_W+1)'(pos_ff) - (POS_W+1)'(perr_ff);
      raw     = ((DER_W-1)'(ediff) <<< 4) + ((DER_W-1)'(ediff) <<< 2);
      dsum    = (DER_W+1)'(raw) + (DER_W+1)'(pder_ff);
      tacc    = acc_ff[ACC_W-1] ? acc_ff + ACC_W'(ONE - 1) : acc_ff;
      cq      = (ACC_W-FRAC_BITS)'(tacc >>> FRAC_BITS);
      cmax    = $signed((ACC_W-FRAC_BITS)'(cfg.max_correction));
      fwd     = det_ff ? $signed(FWD_W'(cfg.base_speed)) : $signed(FWD_W'(cfg.search_speed));
      lsum    = fwd - FWD_W'(corr_ff);
      rsum    = fwd + FWD_W'(corr_ff);
      vmax    = $signed(FWD_W'(cfg.max_speed));

      case (cmd.op)
         OP_ACCUM: begin
            // readings past the sensor count are dropped
            if (seen_ff < SEEN_W'(MAX_SENSORS)) begin
               vsum_in = vsum_ff + VSUM_W'(v);
               iws_in  = iws_ff + IWS_W'($signed({1'b0, seen_ff}) * v);
               seen_in = seen_ff + 1'b1;
            end
         end
         OP_CENTRE: begin
            w_in   = W_W'(iws_ff) - W_W'($signed({1'b0, centre}) * vsum_ff);
            det_in = vsum_ff > $signed(VSUM_W'(LINE_THRESH));
         end
         OP_DIV_INIT: begin
            neg_in = w_ff[W_W-1];
            dvd_in = DVD_W'(wmag) << FRAC_BITS;
            rem_in = '0;
         end
         OP_DIV_STEP: begin
            // restoring step, quotient bits shift into dvd_ff
            if (trial >= divisor) begin
               rem_in = trial - divisor;
               dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
            end
         end
         OP_POSITION: begin
            if (!det_ff)
               pos_in = '0;
            else if (neg_ff)
               pos_in = (dvd_ff > DVD_W'(32768)) ? $signed(POS_W'(32768))
                                                 : $signed(POS_W'(DVD_W'(0) - dvd_ff));
            else
               pos_in = (dvd_ff > DVD_W'(32767)) ? $signed(POS_W'(32767))
                                                 : $signed(POS_W'(dvd_ff));
         end
         OP_INTEG: begin
            // anti-windup clamp
            if (isum > ilim)       integ_in = INTEG_W'(ilim);
            else if (isum < -ilim) integ_in = INTEG_W'(-ilim);
            else                   integ_in = INTEG_W'(isum);
         end
         OP_DERIV: begin
            // half of raw plus previous, truncated toward zero
            der_in = DER_W'((dsum + (DER_W+1)'(dsum[DER_W])) >>> 1);
         end
         OP_MUL_I: acc_in = ACC_W'(prod_ff);
         OP_MUL_D: acc_in = acc_ff + ACC_W'(prod_ff);
         OP_SUM:   acc_in = acc_ff + ACC_W'(prod_ff);
         OP_CORR: begin
            if (!det_ff)
               corr_in = perr_ff[POS_W-1] ? $signed(-CORR_W'(TURN)) : $signed(CORR_W'(TURN));
            else if (cq > cmax)
               corr_in = CORR_W'(cmax);
            else if (cq < -cmax)
               corr_in = CORR_W'(-cmax);
            else
               corr_in = CORR_W'(cq);
         end
         OP_RESULT: begin
            if (lsum > vmax)       left_in = SPD_W'(vmax);
            else if (lsum < -vmax) left_in = SPD_W'(-vmax);
            else                   left_in = SPD_W'(lsum);
            if (rsum > vmax)       right_in = SPD_W'(vmax);
            else if (rsum < -vmax) right_in = SPD_W'(-vmax);
            else                   right_in = SPD_W'(rsum);
            odet_in = det_ff;
            opos_in = pos_ff;
            perr_in = pos_ff;
            pder_in = der_ff;
            vsum_in = '0;
            iws_in  = '0;
            seen_in = '0;
         end
         OP_EMPTY: begin
            left_in  = '0;
            right_in = '0;
            odet_in  = 1'b0;
            opos_in  = '0;
         end
         default: begin
            vsum_in = vsum_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vsum_ff  <= '0;
         iws_ff   <= '0;
         seen_ff  <= '0;
         integ_ff <= '0;
         perr_ff  <= '0;
         pder_ff  <= '0;
      end else begin
         vsum_ff  <= vsum_in;
         iws_ff   <= iws_in;
         seen_ff  <= seen_in;
         integ_ff <= integ_in;
         perr_ff  <= perr_in;
         pder_ff  <= pder_in;
      end
   end

   // working and result registers, no reset needed
   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      det_ff   <= det_in;
      neg_ff   <= neg_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      pos_ff   <= pos_in;
      der_ff   <= der_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      corr_ff  <= corr_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      odet_ff  <= odet_in;
      opos_ff  <= opos_in;
   end

   assign left_speed    = left_ff;
   assign right_speed   = right_ff;
   assign line_found    = odet_ff;
   assign line_position = opos_ff;

endmodule

### rtl/line_follow_pid_drive.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive
// Line follower: centroid of line-sensor readings, PID, differential drive.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one sensor reading per word; last_in_frame closes a frame,
//   empty_frame asks for a stop command and leaves all state untouched.
//   rsp_ch carries one drive command per closed or empty frame.
//   csr_* writes the gain, speed and limit registers; write only while idle.
// Sequence:
//   A reading that does not close a frame only adds to the frame sums.
//   A closing reading goes through the one-bit-per-cycle centroid divider,
//   then single steps of the shared 16x25 multiplier and the PID
//   arithmetic before its command is loaded.
//   An empty frame goes to the stop state, which loads its command once the output register is free.
//   req_ch.ready is high only while the sequencer is idle.
// Reset:
//   Synchronous; clears the frame sums and PID state and loads register
//   defaults. No result is pending afterwards.
// Stall:
//   A command waits in the output register; a following reading is still
//   taken, and the next command holds in its final step until rsp_ch.ready.
// ----------------------------------------------------------------------------
module line_follow_pid_drive
   import lfpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   lfpd_req_if.sink         req_ch,
   lfpd_rsp_if.source       rsp_ch,
   input  logic             csr_write_enable,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_write_data
);

   cfg_type cfg;
   cmd_type cmd;

   lfpd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lfpd_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_last_in_frame (req_ch.last_in_frame),
      .req_empty_frame   (req_ch.empty_frame),
      .req_ready         (req_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .cmd               (cmd)
   );

   lfpd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .sensor_value  (req_ch.sensor_value),
      .left_speed    (rsp_ch.left_speed),
      .right_speed   (rsp_ch.right_speed),
      .line_found    (rsp_ch.line_found),
      .line_position (rsp_ch.line_position)
   );

endmodule

### tb/sv/lfpd_chk.sv
// ----------------------------------------------------------------------------
// lfpd_chk
// Drive command checker: watches the reading and command channels, predicts
// each command from the accepted readings and compares it field by field.
// ----------------------------------------------------------------------------
module lfpd_chk
   import lfpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   lfpd_req_if              req_mon,
   lfpd_rsp_if              rsp_mon,
   input  logic             csr_write_enable,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_write_data,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic signed [SPD_W-1:0] left_speed;
      logic signed [SPD_W-1:0] right_speed;
      logic                    line_found;
      logic signed [POS_W-1:0] line_position;
   } drive_cmd_type;

   drive_cmd_type cmd_queue[$];
   cfg_type       cfg;

   longint frame_sum, frame_wsum, integ, prev_err, prev_der;
   int     seen;

   function automatic longint clip(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   // one accepted reading; returns 1 with a command when a frame closes or is empty
   function automatic bit drive_predict(logic [SENSOR_W-1:0] sv, logic last, logic empty,
                                        output drive_cmd_type cmd);
      longint v, centre, w, pos, err, raw, der, corr, fwd, l, r;
      bit det;
      cmd = '0;
      if (empty) return 1;
      if (seen < MAX_SENSORS) begin
         v = longint'(ONE) - longint'(sv);
         frame_sum += v;
         frame_wsum += seen * v;
         seen++;
      end
      if (!last) return 0;
      centre = (seen - 1) / 2;
      w = frame_wsum - centre * frame_sum;
      det = frame_sum > LINE_THRESH;
      pos = det ? clip((w * ONE) / frame_sum, -32768, 32767) : 0;
      err = pos;
      integ = clip(integ + err / 20, -longint'(cfg.integral_limit),
                   longint'(cfg.integral_limit));
      raw = 20 * (err - prev_err);
      der = (raw + prev_der) / 2;
      corr = (longint'(cfg.gain_p) * err + longint'(cfg.gain_i) * integ
              + longint'(cfg.gain_d) * der) / ONE;
      corr = clip(corr, -longint'(cfg.max_correction), longint'(cfg.max_correction));
      fwd = cfg.base_speed;
      if (!det) begin
         fwd = cfg.search_speed;
         corr = (prev_err >= 0) ? TURN : -TURN;
      end
      l = clip(fwd - corr, -longint'(cfg.max_speed), longint'(cfg.max_speed));
      r = clip(fwd + corr, -longint'(cfg.max_speed), longint'(cfg.max_speed));
      prev_err = err;
      prev_der = der;
      frame_sum = 0;
      frame_wsum = 0;
      seen = 0;
      cmd.left_speed = l[SPD_W-1:0];
      cmd.right_speed = r[SPD_W-1:0];
      cmd.line_found = det;
      cmd.line_position = pos[POS_W-1:0];
      return 1;
   endfunction

   always @(posedge clock) begin
      drive_cmd_type exp_cmd, got;
      if (reset) begin
         cfg.gain_p <= 15'd3686;
         cfg.gain_i <= 15'd205;
         cfg.gain_d <= 15'd737;
         cfg.base_speed <= 13'd3277;
         cfg.max_speed <= 13'd4096;
         cfg.max_correction <= 14'd3482;
         cfg.integral_limit <= 15'd8192;
         cfg.search_speed <= 13'd2253;
         frame_sum = 0; frame_wsum = 0; seen = 0;
         integ = 0; prev_err = 0; prev_der = 0;
         cmd_queue.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               REG_GAIN_P:         cfg.gain_p <= csr_write_data[14:0];
               REG_GAIN_I:         cfg.gain_i <= csr_write_data[14:0];
               REG_GAIN_D:         cfg.gain_d <= csr_write_data[14:0];
               REG_BASE_SPEED:     cfg.base_speed <= csr_write_data[12:0];
               REG_MAX_SPEED:      cfg.max_speed <= csr_write_data[12:0];
               REG_MAX_CORRECTION: cfg.max_correction <= csr_write_data[13:0];
               REG_INTEGRAL_LIMIT: cfg.integral_limit <= csr_write_data[14:0];
               REG_SEARCH_SPEED:   cfg.search_speed <= csr_write_data[12:0];
               default: ;
            endcase
         end
         // predict from accepted readings
         if (req_mon.valid && req_mon.ready) begin
            if (drive_predict(req_mon.sensor_value, req_mon.last_in_frame,
                              req_mon.empty_frame, exp_cmd))
               cmd_queue.push_back(exp_cmd);
         end
         // compare accepted commands
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.left_speed, rsp_mon.right_speed, rsp_mon.line_found,
                    rsp_mon.line_position};
            if (cmd_queue.size() == 0) begin
               $error("unexpected command word");
               fail_count <= fail_count + 1;
            end else begin
               exp_cmd = cmd_queue.pop_front();
               if (got != exp_cmd) begin
                  fail_count <= fail_count + 1;
                  if (got.left_speed != exp_cmd.left_speed)
                     $error("left_speed exp %0d got %0d", exp_cmd.left_speed, got.left_speed);
                  if (got.right_speed != exp_cmd.right_speed)
                     $error("right_speed exp %0d got %0d", exp_cmd.right_speed,
                            got.right_speed);
                  if (got.line_found != exp_cmd.line_found)
                     $error("line_found exp %0d got %0d", exp_cmd.line_found,
                            got.line_found);
                  if (got.line_position != exp_cmd.line_position)
                     $error("line_position exp %0d got %0d", exp_cmd.line_position,
                            got.line_position);
               end
            end
         end
         pending_count <= cmd_queue.size();
      end
   end

endmodule

### tb/sv/line_follow_pid_drive_tb.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive_tb
// Drives sensor frames through the line follower under random gaps and
// stalls, across several register settings; the checker predicts commands.
// ----------------------------------------------------------------------------
module line_follow_pid_drive_tb;
   import lfpd_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_write_data;
   int               fail_count;
   int               pending_count;
   int               idle_cycles;
   bit               stall_mode;

   lfpd_req_if req_ch ();
   lfpd_rsp_if rsp_ch ();

   line_follow_pid_drive uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   lfpd_chk chk (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: phases of no stall and of heavy stall
   always @(negedge clock) begin
      if (reset) begin
         stall_mode <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(logic [SENSOR_W-1:0] sv, logic last, logic empty);
      req_ch.valid = 1'b1;
      req_ch.sensor_value = sv;
      req_ch.last_in_frame = last;
      req_ch.empty_frame = empty;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, int val);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = val[CFG_W-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic drain_wait();
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic logic [SENSOR_W-1:0] rand_reading();
      case ($urandom_range(0, 5))
         0: return 13'd0;
         1: return 13'd4096;
         2: return 13'($urandom_range(4097, 8191));
         3: return 13'($urandom_range(4000, 4096));
         default: return 13'($urandom_range(0, 4096));
      endcase
   endfunction

   // one frame of n words; some words are preceded by a random gap
   task automatic send_frame(int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clock);
         send_word(rand_reading(), k == n - 1, 1'b0);
      end
   endtask

   task automatic random_config(bit extreme);
      int hi;
      for (int r = 0; r < 8; r++) begin
         case (IDX_W'(r))
            REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_INTEGRAL_LIMIT: hi = 32767;
            REG_MAX_CORRECTION: hi = 8192;
            default: hi = 4096;
         endcase
         write_reg(IDX_W'(r), extreme ? ($urandom_range(0, 1) ? hi : 0)
                                      : $urandom_range(0, hi));
      end
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.sensor_value = '0;
      req_ch.last_in_frame = 1'b0;
      req_ch.empty_frame = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_GAIN_P;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, lost line, empty frames, overlong frame
      send_word(13'd0, 1'b1, 1'b0);
      send_word(13'd4096, 1'b1, 1'b0);
      send_word(13'h1FFF, 1'b0, 1'b0);
      send_word(13'd0, 1'b1, 1'b0);
      send_word(13'd0, 1'b0, 1'b0);
      send_word(13'd0, 1'b0, 1'b1);
      send_word(13'h1FFF, 1'b1, 1'b1);
      send_word(13'd4096, 1'b1, 1'b0);
      for (int k = 0; k < 11; k++) send_word(k == 10 ? 13'd0 : 13'd4096, k == 10, 1'b0);
      drain_wait();

      // phases with different register settings
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 1) random_config(1'b1);
         else if (ph == 2) begin
            write_reg(REG_GAIN_P, 32767); write_reg(REG_GAIN_I, 32767);
            write_reg(REG_GAIN_D, 32767); write_reg(REG_BASE_SPEED, 4096);
            write_reg(REG_MAX_SPEED, 4096); write_reg(REG_MAX_CORRECTION, 8192);
            write_reg(REG_INTEGRAL_LIMIT, 32767); write_reg(REG_SEARCH_SPEED, 4096);
         end else if (ph == 3) begin
            write_reg(REG_GAIN_P, 0); write_reg(REG_GAIN_I, 0);
            write_reg(REG_GAIN_D, 0); write_reg(REG_BASE_SPEED, 0);
            write_reg(REG_MAX_SPEED, 0); write_reg(REG_MAX_CORRECTION, 0);
            write_reg(REG_INTEGRAL_LIMIT, 0); write_reg(REG_SEARCH_SPEED, 0);
         end else if (ph > 3) random_config(1'b0);
         sent = 0;
         while (sent < 65) begin
            if ($urandom_range(0, 15) == 0) begin
               send_word(rand_reading(), 1'($urandom_range(0, 1)), 1'b1);
               sent++;
            end else begin
               int n;
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
               send_frame(n);
               sent += n;
            end
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(5, 40)) @(negedge clock);
            if ($urandom_range(0, 20) == 0) while (pending_count != 0) @(negedge clock);
         end
         drain_wait();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
